// ===== rtl/core/rsc_pkg.sv =====
package rsc_pkg;

  // Patch segment store
  localparam int SEG_COUNT = 256;
  localparam int SEG_IDX_W = (SEG_COUNT > 1) ? $clog2(SEG_COUNT) : 1;
  localparam logic [8:0] SEG_LIMIT = 9'(SEG_COUNT);

  // Word widths
  localparam int OFF_W  = 32;
  localparam int SEG_W  = 8;
  localparam int KIND_W = 8;
  localparam int BYTE_W = 8;

  // Run geometry: escape + up to five varint bytes + up to four metadata bytes
  localparam int RUN_MAX       = 10;
  localparam int RUN_CNT_W     = 4;
  localparam int VARINT_GROUPS = 5;
  localparam int META_MAX      = 4;

  localparam logic [BYTE_W-1:0] ESC_BYTE      = 8'hFF;
  localparam logic [BYTE_W-1:0] CONT_BIT      = 8'h80;
  localparam logic [OFF_W-1:0]  SHORT_MAX_DLT = 32'd28;
  localparam logic [OFF_W-1:0]  EXT_MAX_DLT   = 32'd124;

  // Relocation kinds with a short form
  localparam logic [KIND_W-1:0] RK_K0 = 8'd0;
  localparam logic [KIND_W-1:0] RK_K2 = 8'd2;
  localparam logic [KIND_W-1:0] RK_K4 = 8'd4;
  localparam logic [KIND_W-1:0] RK_K5 = 8'd5;
  localparam logic [KIND_W-1:0] RK_K6 = 8'd6;

  // Short codes
  localparam logic [2:0] SC_K0 = 3'd0;
  localparam logic [2:0] SC_K2 = 3'd1;
  localparam logic [2:0] SC_K4 = 3'd2;
  localparam logic [2:0] SC_K5 = 3'd3;
  localparam logic [2:0] SC_K6 = 3'd4;

  // Extended short codes
  localparam logic [2:0] XC_K2 = 3'd5;
  localparam logic [2:0] XC_K4 = 3'd6;
  localparam logic [2:0] XC_K6 = 3'd7;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== rtl/core/rsc_if.sv =====
interface rsc_in_if import rsc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OFF_W-1:0]  patch_offset;
  logic [SEG_W-1:0]  patch_seg;
  logic [SEG_W-1:0]  target_seg;
  logic [KIND_W-1:0] reloc_kind;

  modport source (
    output valid, patch_offset, patch_seg, target_seg, reloc_kind,
    input  ready
  );
  modport sink (
    input  valid, patch_offset, patch_seg, target_seg, reloc_kind,
    output ready
  );
endinterface

interface rsc_out_if import rsc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              end_of_run;

  modport source (
    output valid, code_byte, end_of_run,
    input  ready
  );
  modport sink (
    input  valid, code_byte, end_of_run,
    output ready
  );
endinterface

// ===== rtl/core/relocation_stream_compactor_top.sv =====
// Relocation stream compactor.
// in_ch carries one relocation per word (offset, patch segment, target segment,
// kind); out_ch carries the encoded byte run, one byte per word, with
// end_of_run set on the last byte of each relocation's run. Runs are 1 to 10
// bytes and come out in input order.
// The first byte of a run becomes valid once its input word has passed the
// read stage, the delta stage and the run buffer, in that order.
// Throughput: one relocation per cycle while runs are one byte long and out_ch
// is ready; a longer run holds the run buffer until its last byte is taken,
// so the output port sets the rate.
// Last offsets per patch segment live in a 256 x 32 synchronous RAM read at
// accept time; a write-back forward covers back-to-back hits on one segment.
// Per-entry valid flops make every segment read as zero after reset, so the
// block takes words from the first cycle after reset, with no clearing pass.
// Reset also drops any run in flight and forgets the previous metadata.
// When out_ch stalls, the current byte holds; the delta and read stages keep
// filling behind it, then in_ch.ready drops.
module relocation_stream_compactor_top import rsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rsc_in_if.sink    in_ch,
  rsc_out_if.source out_ch
);

  // ---------------- handshake ----------------
  logic in_fire, out_fire;
  logic s1_adv, s2_adv, run_free, s1_ready, s2_ready;

  logic                 s1_v_r;
  logic [OFF_W-1:0]     s1_off_r;
  logic [SEG_W-1:0]     s1_ps_r;
  logic [SEG_W-1:0]     s1_ts_r;
  logic [KIND_W-1:0]    s1_kind_r;

  logic                 s2_v_r;
  logic                 s2_nonneg_r;
  logic [OFF_W-1:0]     s2_mag_r;
  logic                 s2_chg_r;
  logic [SEG_W-1:0]     s2_ps_r;
  logic [SEG_W-1:0]     s2_ts_r;
  logic [KIND_W-1:0]    s2_kind_r;

  byte_t                run_buf_r [RUN_MAX];
  logic [RUN_CNT_W-1:0] run_cnt_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign run_free = (run_cnt_r == '0) || ((run_cnt_r == RUN_CNT_W'(1)) && out_ch.ready);
  assign s2_adv   = s2_v_r && run_free;
  assign s2_ready = !s2_v_r || run_free;
  assign s1_adv   = s1_v_r && s2_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ch.ready = s1_ready;

  // ---------------- last-offset store ----------------
  logic [OFF_W-1:0]     seg_mem [SEG_COUNT];
  logic [SEG_COUNT-1:0] seg_valid_r;
  logic [OFF_W-1:0]     mem_q_r;
  logic                 mem_hit_r;
  logic [SEG_IDX_W-1:0] rd_idx, wr_idx;
  logic                 s1_in_store;

  assign rd_idx      = in_ch.patch_seg[SEG_IDX_W-1:0];
  assign wr_idx      = s1_ps_r[SEG_IDX_W-1:0];
  assign s1_in_store = {1'b0, s1_ps_r} < SEG_LIMIT;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_q_r <= seg_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_in_store) begin
      seg_mem[wr_idx] <= s1_off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_valid_r <= '0;
      mem_hit_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        mem_hit_r <= seg_valid_r[rd_idx];
      end
      if (s1_adv && s1_in_store) begin
        seg_valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  // ---------------- stage 1: read result, delta ----------------
  logic                 fwd_v_r;
  logic [OFF_W-1:0]     fwd_off_r;
  logic                 prev_v_r;
  logic [KIND_W-1:0]    prev_kind_r;
  logic [SEG_W-1:0]     prev_ps_r;
  logic [SEG_W-1:0]     prev_ts_r;

  logic [OFF_W-1:0]     s1_last;
  logic                 s1_nonneg;
  logic [OFF_W-1:0]     s1_mag;
  logic                 s1_chg;

  always_comb begin
    // the word just ahead may have written this segment after our read
    if (fwd_v_r && (prev_ps_r == s1_ps_r)) begin
      s1_last = fwd_off_r;
    end else if (s1_in_store && mem_hit_r) begin
      s1_last = mem_q_r;
    end else begin
      s1_last = '0;
    end
    s1_nonneg = s1_off_r >= s1_last;
    s1_mag    = s1_nonneg ? (s1_off_r - s1_last) : (s1_last - s1_off_r);
    s1_chg    = !prev_v_r || (s1_kind_r != prev_kind_r) ||
                (s1_ps_r != prev_ps_r) || (s1_ts_r != prev_ts_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      fwd_v_r     <= 1'b0;
      prev_v_r    <= 1'b0;
      prev_kind_r <= '0;
      prev_ps_r   <= '0;
      prev_ts_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        fwd_v_r     <= s1_in_store;
        prev_v_r    <= 1'b1;
        prev_kind_r <= s1_kind_r;
        prev_ps_r   <= s1_ps_r;
        prev_ts_r   <= s1_ts_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_off_r  <= in_ch.patch_offset;
      s1_ps_r   <= in_ch.patch_seg;
      s1_ts_r   <= in_ch.target_seg;
      s1_kind_r <= in_ch.reloc_kind;
    end
    if (s1_adv) begin
      fwd_off_r <= s1_off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_adv) begin
      s2_v_r <= 1'b1;
    end else if (s2_adv) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_nonneg_r <= s1_nonneg;
      s2_mag_r    <= s1_mag;
      s2_chg_r    <= s1_chg;
      s2_ps_r     <= s1_ps_r;
      s2_ts_r     <= s1_ts_r;
      s2_kind_r   <= s1_kind_r;
    end
  end

  // ---------------- stage 2: build the run ----------------
  logic                 has_sc, has_xc;
  logic [2:0]           sc, xc;
  logic                 aligned, short_ok, ext_ok, packed_ok;
  logic [32:0]          zz;
  logic [34:0]          tag;
  logic [6:0]           vgrp [VARINT_GROUPS];
  logic [2:0]           vn;
  logic [2:0]           mcnt;
  byte_t                packed_b;
  byte_t                meta [META_MAX];
  byte_t                ld_buf [RUN_MAX];
  logic [RUN_CNT_W-1:0] ld_cnt;

  always_comb begin
    has_sc = 1'b0;
    has_xc = 1'b0;
    sc     = SC_K0;
    xc     = XC_K2;
    unique case (s2_kind_r)
      RK_K0: begin
        has_sc = 1'b1;
        sc     = SC_K0;
      end
      RK_K2: begin
        has_sc = 1'b1;
        sc     = SC_K2;
        has_xc = 1'b1;
        xc     = XC_K2;
      end
      RK_K4: begin
        has_sc = 1'b1;
        sc     = SC_K4;
        has_xc = 1'b1;
        xc     = XC_K4;
      end
      RK_K5: begin
        has_sc = 1'b1;
        sc     = SC_K5;
      end
      RK_K6: begin
        has_sc = 1'b1;
        sc     = SC_K6;
        has_xc = 1'b1;
        xc     = XC_K6;
      end
      default: begin
        has_sc = 1'b0;
        has_xc = 1'b0;
      end
    endcase
  end

  always_comb begin
    aligned  = s2_nonneg_r && (s2_mag_r[1:0] == 2'b00);
    short_ok = has_sc && (s2_ps_r < SEG_W'(2)) && (s2_ts_r < SEG_W'(2)) &&
               aligned && (s2_mag_r <= SHORT_MAX_DLT);
    ext_ok   = has_xc && (s2_ps_r == '0) && (s2_ts_r == '0) && aligned &&
               (s2_mag_r <= EXT_MAX_DLT) &&
               !((xc == XC_K6) && (s2_mag_r == EXT_MAX_DLT));

    // zigzag, then the metadata-changed flag as bit 0
    zz  = s2_nonneg_r ? {s2_mag_r, 1'b0} : ({s2_mag_r, 1'b0} - 33'd1);
    tag = {1'b0, zz, s2_chg_r};
    vn  = 3'd1;
    for (int i = 0; i < VARINT_GROUPS; i++) begin
      vgrp[i] = tag[7*i +: 7];
      if ((i > 0) && (vgrp[i] != '0)) begin
        vn = 3'(i + 1);
      end
    end

    packed_b  = {s2_ts_r[1:0], s2_ps_r[1:0], s2_kind_r[3:0]};
    packed_ok = (s2_kind_r < KIND_W'(16)) && (s2_ps_r < SEG_W'(4)) &&
                (s2_ts_r < SEG_W'(4)) && (packed_b != ESC_BYTE);
    meta[0] = packed_ok ? packed_b : ESC_BYTE;
    meta[1] = s2_kind_r;
    meta[2] = s2_ps_r;
    meta[3] = s2_ts_r;
    if (!s2_chg_r) begin
      mcnt = 3'd0;
    end else if (packed_ok) begin
      mcnt = 3'd1;
    end else begin
      mcnt = 3'd4;
    end

    for (int j = 0; j < RUN_MAX; j++) begin
      ld_buf[j] = '0;
    end

    priority if (short_ok) begin
      ld_buf[0] = {s2_mag_r[4:2], s2_ts_r[0], s2_ps_r[0], sc};
      ld_cnt    = RUN_CNT_W'(1);
    end else if (ext_ok) begin
      ld_buf[0] = {s2_mag_r[6:2], xc};
      ld_cnt    = RUN_CNT_W'(1);
    end else begin
      ld_buf[0] = ESC_BYTE;
      for (int i = 0; i < VARINT_GROUPS; i++) begin
        ld_buf[i+1] = {(3'(i + 1) < vn), vgrp[i]};
      end
      for (int j = 1; j < RUN_MAX; j++) begin
        for (int k = 0; k < META_MAX; k++) begin
          if ((3'(k) < mcnt) &&
              (RUN_CNT_W'(j) == RUN_CNT_W'(1) + RUN_CNT_W'(vn) + RUN_CNT_W'(k))) begin
            ld_buf[j] = meta[k];
          end
        end
      end
      ld_cnt = RUN_CNT_W'(1) + RUN_CNT_W'(vn) + RUN_CNT_W'(mcnt);
    end
  end

  // ---------------- run buffer / output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
    end else if (s2_adv) begin
      run_cnt_r <= ld_cnt;
    end else if (out_fire) begin
      run_cnt_r <= run_cnt_r - RUN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      run_buf_r <= ld_buf;
    end else if (out_fire) begin
      for (int i = 0; i < RUN_MAX - 1; i++) begin
        run_buf_r[i] <= run_buf_r[i+1];
      end
    end
  end

  assign out_ch.valid      = run_cnt_r != '0;
  assign out_ch.code_byte  = run_buf_r[0];
  assign out_ch.end_of_run = run_cnt_r == RUN_CNT_W'(1);

endmodule

// ===== rtl/core/rsc_checker.sv =====
module rsc_checker import rsc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_code_byte,
  input logic              out_end_of_run
);

  logic                 at_start_r;
  logic [RUN_CNT_W-1:0] run_len_r;
  logic                 out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      run_len_r  <= '0;
    end else if (out_fire) begin
      at_start_r <= out_end_of_run;
      run_len_r  <= out_end_of_run ? '0 : run_len_r + RUN_CNT_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_code_byte) && $stable(out_end_of_run))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a run that opens with the escape byte is a long form and never one byte
  a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && at_start_r && (out_code_byte == ESC_BYTE) |-> !out_end_of_run)
    else $error("escape byte ended its run");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> (run_len_r < RUN_CNT_W'(RUN_MAX - 1)) || out_end_of_run)
    else $error("run longer than the maximum");

endmodule

bind relocation_stream_compactor_top rsc_checker u_rsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_code_byte  (out_ch.code_byte),
  .out_end_of_run (out_ch.end_of_run)
);

// ===== tb/tb_relocation_stream_compactor_top.sv =====
module tb_relocation_stream_compactor_top;
  import rsc_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int WDOG_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    byte_t code;
    logic  eor;
  } run_byte_t;

  logic clk;
  logic rst_n;

  rsc_in_if  in_ch();
  rsc_out_if out_ch();

  relocation_stream_compactor_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state
  logic [OFF_W-1:0]  seg_last_off [SEG_COUNT];
  logic [KIND_W-1:0] last_kind;
  logic [SEG_W-1:0]  last_pseg;
  logic [SEG_W-1:0]  last_tseg;
  logic              seen_any;

  run_byte_t pending_bytes[$];
  int        fail_cnt = 0;
  logic      src_idle_en;
  logic      sink_idle_en;
  logic      sink_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_history();
    for (int i = 0; i < SEG_COUNT; i++) seg_last_off[i] = '0;
    last_kind = '0;
    last_pseg = '0;
    last_tseg = '0;
    seen_any  = 1'b0;
  endfunction

  // Works out the byte run for one relocation and queues it.
  function automatic void encode_reloc(logic [OFF_W-1:0] off, logic [SEG_W-1:0] ps,
                                       logic [SEG_W-1:0] ts, logic [KIND_W-1:0] kind);
    logic [OFF_W-1:0] base;
    logic [OFF_W-1:0] mag;
    logic             in_store;
    logic             nonneg;
    logic             aligned;
    logic             changed;
    logic             has_sc;
    logic             has_xc;
    logic [2:0]       sc;
    logic [2:0]       xc;
    logic [63:0]      zz;
    logic [63:0]      tag;
    byte_t            b;
    byte_t            meta_byte;
    byte_t            run[$];
    run_byte_t        rb;

    in_store = ({1'b0, ps} < SEG_LIMIT);
    base     = in_store ? seg_last_off[ps] : '0;
    nonneg   = (off >= base);
    mag      = nonneg ? off - base : base - off;
    aligned  = (mag[1:0] == 2'b00);
    has_sc   = 1'b0;
    has_xc   = 1'b0;
    sc       = SC_K0;
    xc       = XC_K2;
    case (kind)
      RK_K0: begin has_sc = 1'b1; sc = SC_K0; end
      RK_K2: begin has_sc = 1'b1; sc = SC_K2; has_xc = 1'b1; xc = XC_K2; end
      RK_K4: begin has_sc = 1'b1; sc = SC_K4; has_xc = 1'b1; xc = XC_K4; end
      RK_K5: begin has_sc = 1'b1; sc = SC_K5; end
      RK_K6: begin has_sc = 1'b1; sc = SC_K6; has_xc = 1'b1; xc = XC_K6; end
      default: ;
    endcase

    if (has_sc && ps < 2 && ts < 2 && nonneg && aligned && mag <= SHORT_MAX_DLT) begin
      run.insert(run.size(), {mag[4:2], ts[0], ps[0], sc});
    end else if (has_xc && ps == 0 && ts == 0 && nonneg && aligned && mag <= EXT_MAX_DLT &&
                 !(xc == XC_K6 && mag == EXT_MAX_DLT)) begin
      run.insert(run.size(), {mag[6:2], xc});
    end else begin
      zz = {31'b0, mag, 1'b0};
      if (!nonneg) zz = zz - 64'd1;
      changed = !seen_any || kind != last_kind || ps != last_pseg || ts != last_tseg;
      tag = {zz[62:0], changed};
      run.insert(run.size(), ESC_BYTE);
      do begin
        b   = {1'b0, tag[6:0]};
        tag = tag >> 7;
        if (tag != 0) b = b | CONT_BIT;
        run.insert(run.size(), b);
      end while (tag != 0);
      if (changed) begin
        meta_byte = kind | (ps << 4) | (ts << 6);
        if (kind < 16 && ps < 4 && ts < 4 && meta_byte != ESC_BYTE) begin
          run.insert(run.size(), meta_byte);
        end else begin
          run.insert(run.size(), ESC_BYTE);
          run.insert(run.size(), kind);
          run.insert(run.size(), ps);
          run.insert(run.size(), ts);
        end
      end
    end

    for (int i = 0; i < run.size(); i++) begin
      rb = {run[i], i == run.size() - 1};
      pending_bytes.insert(pending_bytes.size(), rb);
    end
    if (in_store) seg_last_off[ps] = off;
    last_kind = kind;
    last_pseg = ps;
    last_tseg = ts;
    seen_any  = 1'b1;
  endfunction

  task automatic send_reloc(logic [OFF_W-1:0] off, logic [SEG_W-1:0] ps,
                            logic [SEG_W-1:0] ts, logic [KIND_W-1:0] kind);
    if (src_idle_en && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.patch_offset <= off;
    in_ch.patch_seg    <= ps;
    in_ch.target_seg   <= ts;
    in_ch.reloc_kind   <= kind;
    do @(posedge clk); while (!in_ch.ready);
    encode_reloc(off, ps, ts, kind);
  endtask

  // Mostly plausible streams (small segments, aligned forward steps, repeated
  // metadata), the rest full-range noise or mid-sized deltas for long varints.
  task automatic send_random_reloc();
    logic [OFF_W-1:0]  off;
    logic [SEG_W-1:0]  ps;
    logic [SEG_W-1:0]  ts;
    logic [KIND_W-1:0] kind;
    int                pick;

    pick = $urandom_range(99);
    if (pick < 70) begin
      if (seen_any && $urandom_range(99) < 40) begin
        ps   = last_pseg;
        ts   = last_tseg;
        kind = last_kind;
      end else begin
        ps = ($urandom_range(99) < 60) ? 8'd0 : 8'($urandom_range(3));
        ts = ($urandom_range(99) < 60) ? 8'd0 : 8'($urandom_range(3));
        case ($urandom_range(5))
          0: kind = RK_K0;
          1: kind = RK_K2;
          2: kind = RK_K4;
          3: kind = RK_K5;
          4: kind = RK_K6;
          default: kind = 8'($urandom_range(15));
        endcase
      end
      off = seg_last_off[ps] + 4 * $urandom_range(0, 40);
      if (pick < 5) off = seg_last_off[ps] - 4 * $urandom_range(1, 40);
      else if (pick < 10) off = off + $urandom_range(1, 3);
    end else if (pick < 85) begin
      off  = $urandom();
      ps   = 8'($urandom_range(255));
      ts   = 8'($urandom_range(255));
      kind = 8'($urandom_range(255));
    end else begin
      ps   = 8'($urandom_range(255));
      ts   = 8'($urandom_range(7));
      kind = 8'($urandom_range(31));
      off  = seg_last_off[ps] + ($urandom() >> $urandom_range(0, 31));
    end
    send_reloc(off, ps, ts, kind);
  endtask

  // Receiver: checks every byte, stalls at random, and runs the long hold-off.
  initial begin
    int        hold_left;
    logic      hold_taken;
    run_byte_t want;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected word code_byte=%02h end_of_run=%0b",
                   $time, out_ch.code_byte, out_ch.end_of_run);
          fail_cnt++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_ch.code_byte !== want.code) begin
            $display("%0t: code_byte mismatch: expected %02h, actual %02h",
                     $time, want.code, out_ch.code_byte);
            fail_cnt++;
          end
          if (out_ch.end_of_run !== want.eor) begin
            $display("%0t: end_of_run mismatch: expected %0b, actual %0b",
                     $time, want.eor, out_ch.end_of_run);
            fail_cnt++;
          end
        end
      end
      if (sink_hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(sink_idle_en && $urandom_range(99) < 9);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  task automatic test_short_forms();
    send_reloc(32'd0,  8'd0, 8'd0, RK_K0);
    send_reloc(32'd28, 8'd0, 8'd0, RK_K2);   // largest short delta
    send_reloc(32'd4,  8'd1, 8'd1, RK_K4);
    send_reloc(32'd32, 8'd1, 8'd0, RK_K5);
    send_reloc(32'd32, 8'd0, 8'd1, RK_K6);
  endtask

  task automatic test_extended_forms();
    send_reloc(32'd64,  8'd0, 8'd0, RK_K2);
    send_reloc(32'd188, 8'd0, 8'd0, RK_K4);  // delta 124
    send_reloc(32'd312, 8'd0, 8'd0, RK_K6);  // 124 with kind 6 has no ext code
    send_reloc(32'd416, 8'd0, 8'd0, RK_K6);
    send_reloc(32'd418, 8'd0, 8'd0, RK_K6);  // unaligned, same metadata
    send_reloc(32'd546, 8'd0, 8'd0, RK_K2);  // just past ext range
  endtask

  task automatic test_long_forms();
    send_reloc(32'd0,         8'd0,   8'd0,   RK_K2);  // negative delta
    send_reloc(32'hffff_ffff, 8'd0,   8'd0,   RK_K2);  // five varint groups
    send_reloc(32'd0,         8'd0,   8'd0,   RK_K2);  // most negative delta
    send_reloc(32'h8000_0000, 8'd255, 8'd255, 8'd255);
    send_reloc(32'h7fff_ffff, 8'd3,   8'd3,   8'd15);  // packed would be escape
    send_reloc(32'd100,       8'd2,   8'd3,   8'd16);
    send_reloc(32'd100,       8'd4,   8'd0,   8'd1);
    send_reloc(32'd100,       8'd0,   8'd4,   8'd3);
    send_reloc(32'd96,        8'd3,   8'd2,   8'd7);
    send_reloc(32'haaaa_aaaa, 8'h55,  8'haa,  8'h55);
    send_reloc(32'h5555_5555, 8'haa,  8'h55,  8'haa);
  endtask

  task automatic test_random_stream(int count, logic idle_on);
    src_idle_en  = idle_on;
    sink_idle_en = idle_on;
    repeat (count) send_random_reloc();
  endtask

  // Sink holds off while the source keeps offering, so the pipe fills.
  task automatic test_output_backpressure();
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b1;
    sink_hold_req = 1'b1;
    repeat (40) send_random_reloc();
  endtask

  initial begin
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    sink_hold_req = 1'b0;
    clear_history();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.patch_offset <= '0;
    in_ch.patch_seg    <= '0;
    in_ch.target_seg   <= '0;
    in_ch.reloc_kind   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_short_forms();
    test_extended_forms();
    test_long_forms();
    test_random_stream(150, 1'b1);
    test_random_stream(100, 1'b0);
    test_output_backpressure();
    test_random_stream(150, 1'b1);

    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_bytes.size());
    end
    if (fail_cnt == 0 && pending_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
